// ===== src/wfps_pkg.sv =====
// Shared constants, types and state codes for the wall-following steering block.
`timescale 1ns / 1ps
package wfps_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CNT_W = $clog2(CORDIC_ITERATIONS);
  localparam int CW = 40;

  localparam int SIN_THETA_Q16 = 56738;
  localparam int COS_THETA_Q16 = 32798;
  localparam int INV_GAIN_Q16 = 39797;
  localparam int NS_PER_SECOND = 1000000000;
  localparam logic [40:0] DTERM_LIMIT = 41'h100_0000_0000;
  localparam logic [32:0] U_TEN = 33'd655360;
  localparam logic [32:0] U_TWENTY = 33'd1310720;
  localparam logic [8:0] SPEED_FAST = 9'd384;
  localparam logic [8:0] SPEED_MID = 9'd256;
  localparam logic [8:0] SPEED_SLOW = 9'd128;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_TARGET_DIST = 3'd3,
    REG_LOOKAHEAD   = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_DIST, S_ERR, S_PMUL, S_IMUL, S_DMUL,
    S_NUM, S_MMUL, S_DSTART, S_DWAIT, S_SUM
  } state_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [31:0] integ_gain;
    logic [15:0] target_distance;
    logic [15:0] lookahead;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/wfps_ranges_if.sv =====
// Handshake channel that carries one lidar range item.
`timescale 1ns / 1ps
interface wfps_ranges_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_a;
  logic [15:0] range_b;
  logic        range_a_valid;
  logic        range_b_valid;
  logic [31:0] timestamp_ns;

  modport source (output valid, range_a, range_b, range_a_valid, range_b_valid,
                  timestamp_ns, input ready);
  modport sink (input valid, range_a, range_b, range_a_valid, range_b_valid,
                timestamp_ns, output ready);
endinterface

// ===== src/wfps_command_if.sv =====
// Handshake channel that carries one steering command item.
`timescale 1ns / 1ps
interface wfps_command_if;
  logic        valid;
  logic        ready;
  logic [31:0] steering;
  logic [8:0]  speed;

  modport source (output valid, steering, speed, input ready);
  modport sink (input valid, steering, speed, output ready);
endinterface

// ===== src/wfps_regs.sv =====
// APB-style configuration registers.
`timescale 1ns / 1ps
module wfps_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output wfps_pkg::cfg_t                cfg
);
  import wfps_pkg::*;

  reg_index_t idx;

  assign idx = reg_index_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain <= 16'd307;
      cfg.deriv_gain <= 16'd205;
      cfg.integ_gain <= 32'd4295;
      cfg.target_distance <= 16'd256;
      cfg.lookahead <= 16'd51;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PROP_GAIN:   cfg.prop_gain <= pwdata[15:0];
        REG_DERIV_GAIN:  cfg.deriv_gain <= pwdata[15:0];
        REG_INTEG_GAIN:  cfg.integ_gain <= pwdata;
        REG_TARGET_DIST: cfg.target_distance <= pwdata[15:0];
        REG_LOOKAHEAD:   cfg.lookahead <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:   prdata = {16'd0, cfg.prop_gain};
      REG_DERIV_GAIN:  prdata = {16'd0, cfg.deriv_gain};
      REG_INTEG_GAIN:  prdata = cfg.integ_gain;
      REG_TARGET_DIST: prdata = {16'd0, cfg.target_distance};
      REG_LOOKAHEAD:   prdata = {16'd0, cfg.lookahead};
      default:         prdata = 32'd0;
    endcase
  end
endmodule

// ===== src/wfps_cordic.sv =====
// CORDIC vectoring unit, one micro-rotation per cycle while step is set, carrying a second vector along.
`timescale 1ns / 1ps
module wfps_cordic (
  input  logic                          clk,
  input  wfps_pkg::cordic_ctrl_t        ctrl,
  input  logic [wfps_pkg::CNT_W-1:0]    shift,
  input  logic [15:0]                   range_a,
  input  logic [15:0]                   range_b,
  input  logic [15:0]                   lookahead,
  output logic signed [wfps_pkg::CW-1:0] p
);
  import wfps_pkg::*;

  logic signed [CW-1:0] x, y, q;
  logic [CW-1:0] ax_sin, ax_cos, b_sh, l_sh;
  logic signed [CW-1:0] dx, dy, dp, dq;

  assign ax_sin = CW'(range_a) * CW'(SIN_THETA_Q16);
  assign ax_cos = CW'(range_a) * CW'(COS_THETA_Q16);
  assign b_sh = CW'({range_b, 16'd0});
  assign l_sh = CW'({lookahead, 16'd0});

  assign dx = y >>> shift;
  assign dy = x >>> shift;
  assign dp = q >>> shift;
  assign dq = p >>> shift;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= $signed(ax_sin);
      y <= $signed(ax_cos) - $signed(b_sh);
      p <= $signed(b_sh);
      q <= $signed(l_sh);
    end else if (ctrl.step) begin
      // Rotate toward y = 0; the second vector follows the same direction.
      if (!y[CW-1]) begin
        x <= x + dx;
        y <= y - dy;
        p <= p + dp;
        q <= q - dq;
      end else begin
        x <= x - dx;
        y <= y + dy;
        p <= p - dp;
        q <= q + dq;
      end
    end
  end
endmodule

// ===== src/wfps_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 32 bits unsigned.
`timescale 1ns / 1ps
module wfps_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           dividend,
  input  logic [31:0]           divisor,
  output logic [63:0]           quotient,
  output wfps_pkg::div_status_t status
);
  import wfps_pkg::*;

  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem[31:0], quotient[63]};
  assign fits = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (status.busy) begin
      rem <= fits ? trial - {1'b0, divisor} : trial;
      quotient <= {quotient[62:0], fits};
    end
  end
endmodule

// ===== src/wall_follow_pid_steering_top.sv =====
// Top level of the wall-following PID steering block.
`timescale 1ns / 1ps
// Each item carries two lidar ranges (30 and 90 degree beams, Q8.8 metres) and a
// nanosecond timestamp. An item with either beam flagged invalid, or with a zero
// 30 degree range, is taken, gives no result and leaves the controller
// state alone. Any other item gives exactly one command item: a saturated
// Q16.16 steering value and a speed step. Such an item passes through 16 CORDIC
// micro-rotations, the shared multiplier and error steps, and the 64 quotient bits
// of the bit-serial divider that scales the derivative term by the time between
// scans; the divider is skipped when the time difference is zero. The next item is
// taken as soon as the sequencer is back in idle, even while the previous command
// still waits in the output register. Gains and target distances are to be written
// over the APB port only while the block is idle; the block itself does not
// enforce this.
module wall_follow_pid_steering_top (
  input  logic                          clk,
  input  logic                          rst,
  wfps_ranges_if.sink                   ranges,
  wfps_command_if.source                command,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wfps_pkg::*;

  cfg_t cfg;
  state_t state, state_next;
  cordic_ctrl_t cordic_ctrl;
  div_status_t div_status;
  logic div_start;
  logic [CNT_W-1:0] cnt;
  logic signed [CW-1:0] p;
  logic [63:0] quotient;

  // Controller state.
  logic signed [16:0] last_error;
  logic signed [31:0] error_sum;
  logic [31:0] last_time;
  logic have_time;
  logic [31:0] time_delta;

  // Per-item working registers.
  logic [31:0] ts;
  logic signed [16:0] err;
  logic signed [17:0] err_diff;
  logic signed [33:0] pterm;
  logic signed [39:0] iterm;
  logic signed [35:0] num;

  // The one shared multiplier and its product register.
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] mul_prod;

  logic item_ok;
  logic signed [68:0] rounded;
  logic signed [36:0] proj_dist;
  logic signed [37:0] diff;
  logic signed [16:0] err_c;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_c;
  logic [40:0] dmag;
  logic signed [41:0] dterm;
  logic signed [43:0] u_sum;
  logic signed [31:0] u_c;
  logic signed [32:0] u_wide;
  logic [32:0] mag_u;
  logic [8:0] speed_c;
  logic out_free;

  wfps_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  wfps_cordic u_cordic (
    .clk,
    .ctrl(cordic_ctrl),
    .shift(cnt),
    .range_a(ranges.range_a),
    .range_b(ranges.range_b),
    .lookahead(cfg.lookahead),
    .p
  );

  wfps_divider u_div (
    .clk, .rst,
    .start(div_start),
    .dividend(mul_prod[63:0]),
    .divisor(time_delta),
    .quotient,
    .status(div_status)
  );

  assign item_ok = ranges.range_a_valid && ranges.range_b_valid && (ranges.range_a != 16'd0);
  assign ranges.ready = (state == S_IDLE);
  assign out_free = !command.valid || command.ready;

  // Projected distance rounded half up to Q8.8, then the clamped error.
  assign rounded = mul_prod + 69'sd2147483648;
  assign proj_dist = rounded[68:32];
  assign diff = 38'(proj_dist) - 38'($signed({1'b0, cfg.target_distance}));
  always_comb begin
    if (diff > 38'sd65535) begin
      err_c = 17'sd65535;
    end else if (diff < -38'sd65536) begin
      err_c = -17'sd65536;
    end else begin
      err_c = diff[16:0];
    end
  end

  assign sum_wide = 33'(error_sum) + 33'(err_c);
  always_comb begin
    if (sum_wide > 33'sd2147483647) begin
      sum_c = 32'sh7FFF_FFFF;
    end else if (sum_wide < -33'sd2147483648) begin
      sum_c = 32'sh8000_0000;
    end else begin
      sum_c = sum_wide[31:0];
    end
  end

  // Derivative magnitude is clamped and takes the sign of the error change.
  always_comb begin
    if (time_delta == 32'd0) begin
      dmag = '0;
    end else if (quotient > 64'(DTERM_LIMIT)) begin
      dmag = DTERM_LIMIT;
    end else begin
      dmag = quotient[40:0];
    end
  end
  assign dterm = num[35] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

  assign u_sum = 44'(pterm) + 44'(iterm) + 44'(dterm);
  always_comb begin
    if (u_sum > 44'sd2147483647) begin
      u_c = 32'sh7FFF_FFFF;
    end else if (u_sum < -44'sd2147483648) begin
      u_c = 32'sh8000_0000;
    end else begin
      u_c = u_sum[31:0];
    end
  end
  assign u_wide = 33'(u_c);
  assign mag_u = u_wide[32] ? 33'(-u_wide) : 33'(u_wide);
  always_comb begin
    if (mag_u < U_TEN) begin
      speed_c = SPEED_FAST;
    end else if (mag_u < U_TWENTY) begin
      speed_c = SPEED_MID;
    end else begin
      speed_c = SPEED_SLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cordic_ctrl = '0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        if (ranges.valid && item_ok) begin
          cordic_ctrl.load = 1'b1;
          state_next = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cordic_ctrl.step = 1'b1;
        if (cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        mul_a = p[35:0];
        mul_b = $signed(33'(INV_GAIN_Q16));
        state_next = S_ERR;
      end
      S_ERR: state_next = S_PMUL;
      S_PMUL: begin
        mul_a = 36'(err);
        mul_b = $signed({17'd0, cfg.prop_gain});
        state_next = S_IMUL;
      end
      S_IMUL: begin
        mul_a = 36'(error_sum);
        mul_b = $signed({1'b0, cfg.integ_gain});
        state_next = S_DMUL;
      end
      S_DMUL: begin
        mul_a = 36'(err_diff);
        mul_b = $signed({17'd0, cfg.deriv_gain});
        state_next = S_NUM;
      end
      S_NUM: state_next = S_MMUL;
      S_MMUL: begin
        mul_a = num[35] ? -num : num;
        mul_b = $signed(33'(NS_PER_SECOND));
        state_next = S_DSTART;
      end
      S_DSTART: begin
        if (time_delta == 32'd0) begin
          state_next = S_SUM;
        end else begin
          div_start = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_status.done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum <= '0;
      last_time <= '0;
      have_time <= 1'b0;
      time_delta <= '0;
      command.valid <= 1'b0;
      cnt <= '0;
    end else begin
      // A new command is loaded only when the output register is free, so the
      // load and the handoff of the previous command never collide.
      if (state == S_SUM && out_free) begin
        command.valid <= 1'b1;
        command.steering <= u_c;
        command.speed <= speed_c;
      end else if (command.valid && command.ready) begin
        command.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          ts <= ranges.timestamp_ns;
        end
        S_CORDIC: cnt <= cnt + CNT_W'(1);
        S_ERR: begin
          err <= err_c;
          err_diff <= 18'(err_c) - 18'(last_error);
          last_error <= err_c;
          error_sum <= sum_c;
          if (have_time) begin
            time_delta <= ts - last_time;
          end
          last_time <= ts;
          have_time <= 1'b1;
        end
        S_IMUL: pterm <= mul_prod[33:0];
        S_DMUL: iterm <= mul_prod[63:24];
        S_NUM: num <= mul_prod[35:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/wfps_checker.sv =====
// Port-level checks for the steering block, bound to its top level.
`timescale 1ns / 1ps
module wfps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        a_valid,
  input logic        b_valid,
  input logic [15:0] range_a,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] steering,
  input logic [8:0]  speed
);
  import wfps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(steering) && $stable(speed))
    else $error("command item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && a_valid && b_valid && (range_a != 16'd0) |=> !in_ready)
    else $error("block took another item while working");

  a_speed_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed == SPEED_FAST || speed == SPEED_MID || speed == SPEED_SLOW)
    else $error("illegal speed step");

  a_speed_fast: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((speed == SPEED_FAST) ==
                   ($signed(steering) < 32'sd655360 && $signed(steering) > -32'sd655360)))
    else $error("fast speed does not match steering magnitude");
endmodule

bind wall_follow_pid_steering_top wfps_checker u_wfps_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(ranges.valid),
  .in_ready(ranges.ready),
  .a_valid(ranges.range_a_valid),
  .b_valid(ranges.range_b_valid),
  .range_a(ranges.range_a),
  .out_valid(command.valid),
  .out_ready(command.ready),
  .steering(command.steering),
  .speed(command.speed)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the wall-following PID steering block.
`timescale 1ns / 1ps
module testbench;
  import wfps_pkg::*;

  // Directed rows either carry an item, a register write, or a typed answer.
  typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_FIXED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] a;
    logic [15:0] b;
    logic        av;
    logic        bv;
    logic [31:0] ts;
    logic [31:0] steer;
    logic [8:0]  speed;
  } row_t;

  typedef struct {
    logic [31:0] steer;
    logic [8:0]  speed;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  wfps_ranges_if ranges ();
  wfps_command_if command ();

  wall_follow_pid_steering_top dut (
    .clk(clk), .rst(rst), .ranges(ranges), .command(command),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the gains and the controller state.
  bit [15:0] kp = 307, kd = 205, tdist = 256, look = 51;
  bit [31:0] ki = 4295;
  logic signed [16:0] last_err = '0;
  logic signed [31:0] err_sum = '0;
  bit [31:0] last_ts = '0, tdelta = '0;
  bit have_ts = 1'b0;

  command_t pending_cmds[$];
  int fail_cnt = 0;
  bit calm = 1'b0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // CORDIC vectoring on the wall vector, with the same micro-rotations applied
  // to (b, lookahead); the result is the projected distance in Q8.8.
  function automatic longint project_dist(longint a, longint b, longint la);
    longint x, y, p, q, dx, dy, dp, dq;
    x = a * SIN_THETA_Q16;
    y = a * COS_THETA_Q16 - b * 65536;
    p = b * 65536;
    q = la * 65536;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = y >>> i; dy = x >>> i; dp = q >>> i; dq = p >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; p += dp; q -= dq;
      end else begin
        x -= dx; y += dy; p -= dp; q += dq;
      end
    end
    return (p * INV_GAIN_Q16 + 64'sd2147483648) >>> 32;
  endfunction

  // Advances the shadow state for one accepted item; returns 1 with the
  // expected command when the item produces one.
  function automatic bit steer_predict(logic [15:0] a, logic [15:0] b, logic av,
                                       logic bv, logic [31:0] ts, output command_t cmd);
    longint err, prev, pterm, iterm, dterm, num, u, mag_u;
    longint unsigned mag;
    if (!av || !bv || a == 0) return 1'b0;
    err = clamp(project_dist(a, b, look) - longint'(tdist), -65536, 65535);
    prev = last_err;
    last_err = err[16:0];
    err_sum = 32'(clamp(longint'(err_sum) + err, -64'sd2147483648, 64'sd2147483647));
    if (have_ts) tdelta = ts - last_ts;
    last_ts = ts;
    have_ts = 1'b1;
    pterm = longint'(kp) * err;
    iterm = (longint'(ki) * longint'(err_sum)) >>> 24;
    dterm = 0;
    if (tdelta != 0) begin
      num = longint'(kd) * (err - prev);
      mag = num < 0 ? -num : num;
      mag = mag * 64'd1000000000 / tdelta;
      if (mag > 64'd1099511627776) mag = 64'd1099511627776;
      dterm = num < 0 ? -longint'(mag) : longint'(mag);
    end
    u = clamp(pterm + iterm + dterm, -64'sd2147483648, 64'sd2147483647);
    mag_u = u < 0 ? -u : u;
    cmd.steer = u[31:0];
    cmd.speed = mag_u < 655360 ? SPEED_FAST : (mag_u < 1310720 ? SPEED_MID : SPEED_SLOW);
    return 1'b1;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   kp = value[15:0];
      REG_DERIV_GAIN:  kd = value[15:0];
      REG_INTEG_GAIN:  ki = value;
      REG_TARGET_DIST: tdist = value[15:0];
      REG_LOOKAHEAD:   look = value[15:0];
      default: ;
    endcase
  endtask

  // Waits for every outstanding command, then lets a dropped item finish.
  task automatic drain(int extra);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Presents one item, holds it until accepted, and books its prediction.
  // When typed is set, the typed answer replaces the predicted one.
  task automatic send_ranges(logic [15:0] a, logic [15:0] b, logic av, logic bv,
                             logic [31:0] ts, bit typed, bit typed_has, command_t typed_cmd);
    command_t cmd;
    bit has;
    while (!calm && $urandom_range(99) < 38) begin
      ranges.valid <= 1'b0;
      @(posedge clk);
    end
    ranges.valid <= 1'b1;
    ranges.range_a <= a; ranges.range_b <= b;
    ranges.range_a_valid <= av; ranges.range_b_valid <= bv;
    ranges.timestamp_ns <= ts;
    do @(posedge clk); while (!ranges.ready);
    has = steer_predict(a, b, av, bv, ts, cmd);
    if (typed) begin
      has = typed_has;
      cmd = typed_cmd;
    end
    if (has) pending_cmds.push_back(cmd);
  endtask

  // Output side: random back-pressure and the comparison against the oldest
  // expectation.
  always @(posedge clk) begin
    command_t want;
    command.ready <= calm || ($urandom_range(99) >= 38);
    if (!rst && command.valid && command.ready) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected command", command.steering, 32'h0);
      end else begin
        want = pending_cmds.pop_front();
        if (command.steering !== want.steer) report("steering", command.steering, want.steer);
        if (command.speed !== want.speed) report("speed", {23'h0, command.speed}, {23'h0, want.speed});
      end
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[] = '{
    // Zero 30 degree range and invalid beams give nothing.
    '{ROW_NONE,  16'h0000, 16'h0100, 1'b1, 1'b1, 32'd10,   32'h0, 9'h0},
    '{ROW_NONE,  16'h0100, 16'h0100, 1'b0, 1'b1, 32'd20,   32'h0, 9'h0},
    '{ROW_NONE,  16'h0100, 16'h0100, 1'b1, 1'b0, 32'd30,   32'h0, 9'h0},
    '{ROW_NONE,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 9'h0},
    '{ROW_NONE,  16'h0000, 16'hFFFF, 1'b1, 1'b1, 32'd40,   32'h0, 9'h0},
    // First timestamp, then a repeated one so the time delta stays zero.
    '{ROW_MODEL, 16'h0100, 16'h0100, 1'b1, 1'b1, 32'd1000, 32'h0, 9'h0},
    '{ROW_MODEL, 16'h0200, 16'h012C, 1'b1, 1'b1, 32'd1000, 32'h0, 9'h0},
    '{ROW_MODEL, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd50_000_000, 32'h0, 9'h0},
    '{ROW_MODEL, 16'h0001, 16'h0000, 1'b1, 1'b1, 32'd90_000_000, 32'h0, 9'h0},
    '{ROW_MODEL, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FF00, 32'h0, 9'h0},
    '{ROW_MODEL, 16'h0001, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0100, 32'h0, 9'h0},
    // All gains zero: the command is zero at full speed.
    '{ROW_WRITE, 16'(REG_PROP_GAIN),  16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_DERIV_GAIN), 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_INTEG_GAIN), 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 9'h0},
    '{ROW_FIXED, 16'h0300, 16'h0080, 1'b1, 1'b1, 32'd2_000_000, 32'h0, 9'd384},
    '{ROW_FIXED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd9_000_000, 32'h0, 9'd384},
    // Largest gains and lookahead with zero target: error and integral saturate.
    '{ROW_WRITE, 16'(REG_PROP_GAIN),  16'h0, 1'b0, 1'b0, 32'hFFFF, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_DERIV_GAIN), 16'h0, 1'b0, 1'b0, 32'hFFFF, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_INTEG_GAIN), 16'h0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_TARGET_DIST), 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 9'h0},
    '{ROW_WRITE, 16'(REG_LOOKAHEAD),  16'h0, 1'b0, 1'b0, 32'hFFFF, 32'h0, 9'h0},
    '{ROW_MODEL, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd1, 32'h0, 9'h0},
    '{ROW_MODEL, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd2, 32'h0, 9'h0},
    // Largest target against a tiny distance drives the error hard negative.
    '{ROW_WRITE, 16'(REG_TARGET_DIST), 16'h0, 1'b0, 1'b0, 32'hFFFF, 32'h0, 9'h0},
    '{ROW_MODEL, 16'h0001, 16'h0000, 1'b1, 1'b1, 32'd3, 32'h0, 9'h0}
  };

  initial begin
    command_t none;
    longint d;
    logic [31:0] ts_now;
    bit good;
    none = '{32'h0, 9'h0};
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    ranges.valid <= 1'b0; ranges.range_a <= '0; ranges.range_b <= '0;
    ranges.range_a_valid <= 1'b0; ranges.range_b_valid <= 1'b0;
    ranges.timestamp_ns <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; register writes happen only once the block is drained.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        ranges.valid <= 1'b0;
        drain(150);
        write_reg(reg_index_t'(dir_rows[i].a[2:0]), dir_rows[i].ts);
      end else begin
        send_ranges(dir_rows[i].a, dir_rows[i].b, dir_rows[i].av, dir_rows[i].bv,
                    dir_rows[i].ts, dir_rows[i].kind != ROW_MODEL,
                    dir_rows[i].kind == ROW_FIXED,
                    '{dir_rows[i].steer, dir_rows[i].speed});
      end
    end

    // Speed boundaries: with only the proportional term, an error of exactly
    // 16 counts gives |u| of ten and 32 counts gives twenty.
    ranges.valid <= 1'b0;
    drain(150);
    write_reg(REG_LOOKAHEAD, 32'd51);
    write_reg(REG_PROP_GAIN, 32'd40960);
    write_reg(REG_DERIV_GAIN, 32'd0);
    write_reg(REG_INTEG_GAIN, 32'd0);
    d = project_dist(2560, 2560, 51);
    write_reg(REG_TARGET_DIST, 32'(d - 16));
    send_ranges(16'd2560, 16'd2560, 1'b1, 1'b1, 32'd100, 1'b0, 1'b0, none);
    ranges.valid <= 1'b0;
    drain(150);
    write_reg(REG_TARGET_DIST, 32'(d - 32));
    send_ranges(16'd2560, 16'd2560, 1'b1, 1'b1, 32'd200, 1'b0, 1'b0, none);

    // Random phases, each with a fresh set of registers. The first keeps the
    // reset-like gains; the fourth runs with no idling on either side.
    ts_now = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      ranges.valid <= 1'b0;
      drain(150);
      calm = (ph == 3);
      if (ph == 0) begin
        write_reg(REG_PROP_GAIN, 32'd307);
        write_reg(REG_DERIV_GAIN, 32'd205);
        write_reg(REG_INTEG_GAIN, 32'd4295);
        write_reg(REG_TARGET_DIST, 32'd256);
        write_reg(REG_LOOKAHEAD, 32'd51);
      end else begin
        write_reg(REG_PROP_GAIN, pick16());
        write_reg(REG_DERIV_GAIN, pick16());
        write_reg(REG_INTEG_GAIN, pick32());
        write_reg(REG_TARGET_DIST, pick16());
        write_reg(REG_LOOKAHEAD, pick16());
      end
      for (int n = 0; n < 110; n++) begin
        logic [15:0] a, b;
        logic av, bv;
        // Hold off once mid-run until every command has come back.
        if (ph == 2 && n == 55) begin
          ranges.valid <= 1'b0;
          drain(0);
        end
        good = $urandom_range(99) < 88;
        a = $urandom_range(3) == 0 ? 16'($urandom_range(2047)) : 16'($urandom);
        b = $urandom_range(3) == 0 ? 16'($urandom_range(2047)) : 16'($urandom);
        av = good ? 1'b1 : 1'($urandom);
        bv = good ? 1'b1 : 1'($urandom);
        if (good && a == 0) a = 16'd1;
        case ($urandom_range(9))
          0: ts_now = ts_now;
          1: ts_now = $urandom;
          2: ts_now = ts_now + $urandom_range(1000);
          default: ts_now = ts_now + $urandom_range(100_000_000);
        endcase
        send_ranges(a, b, av, bv, ts_now, 1'b0, 1'b0, none);
      end
    end
    ranges.valid <= 1'b0;
    calm = 1'b0;
    drain(150);

    if (fail_cnt == 0 && pending_cmds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
